// ===== design/buddy_block_allocator_unit_macros.svh =====
// Assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, masked during reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator
package bba_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int SLOT_W     = 9;
  localparam int SIZE_W     = 15;
  localparam int OFF_W      = 14;
  localparam int MIN_SHIFT  = 5;
  localparam int MAX_SHIFT  = 14;
  localparam logic [SIZE_W-1:0] MIN_BLOCK = 15'd32;
  localparam logic [SIZE_W-1:0] MAX_BLOCK = 15'd16384;

  localparam logic       MODE_ALLOC = 1'b0;
  localparam logic       MODE_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ARD,
    S_AEV,
    S_ASPLIT,
    S_ABT,
    S_FRD,
    S_FEV,
    S_FCHK,
    S_FBEV,
    S_FWLO,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SIZE_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  granted_offset;
    logic [SIZE_W-1:0] block_bytes;
  } res_t;

  // smallest power of two, at least MIN_BLOCK, that holds req (req <= MAX_BLOCK)
  function automatic logic [SIZE_W-1:0] calc_need(input logic [SIZE_W-1:0] req);
    logic [SIZE_W-1:0] n;
    n = MAX_BLOCK;
    for (int i = MAX_SHIFT; i >= MIN_SHIFT; i--) begin
      if (req <= (SIZE_W'(1) << i)) n = SIZE_W'(1) << i;
    end
    return n;
  endfunction

endpackage

// ===== design/bba_if.sv =====
// Valid/ready channel interfaces for requests and results
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bba_pkg::SIZE_W-1:0]  request_size;
  logic [bba_pkg::OFF_W-1:0]   block_offset;
  modport source (output valid, mode, request_size, block_offset, input ready);
  modport sink   (input valid, mode, request_size, block_offset, output ready);
endinterface

interface bba_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [bba_pkg::OFF_W-1:0]   granted_offset;
  logic [bba_pkg::SIZE_W-1:0]  block_bytes;
  modport source (output valid, status, granted_offset, block_bytes, input ready);
  modport sink   (input valid, status, granted_offset, block_bytes, output ready);
endinterface

// ===== design/buddy_block_allocator_unit.sv =====
// Buddy block allocator top level: control table RAM, sequencer, result register
// Alloc: a table read and evaluation per node, a write per split, a step per backtrack move;
//   a request over the largest block goes straight to the result beat.
// Free: a misaligned offset goes straight to the result beat; else the entry is read and merged with each free buddy.
// Overlap: the sequencer works on one request at a time; the next beat is taken as the result beat is offered.
// Reset (synchronous, rst_n low) starts a pass that initialises all 512 table entries; no beat till then.
module buddy_block_allocator_unit (
  input  logic         clk,
  input  logic         rst_n,
  bba_in_if.sink       in_ch,
  bba_out_if.source    out_ch
);
  bba_pkg::mem_req_t          mem_req;
  logic [bba_pkg::SIZE_W-1:0] mem_rdata;
  logic                       res_valid, res_ready;
  bba_pkg::res_t              res;
  logic                       out_valid_r, out_valid_nxt;
  bba_pkg::res_t              out_data_r, out_data_nxt;

  bba_ram #(
    .WIDTH (bba_pkg::SIZE_W),
    .DEPTH (bba_pkg::SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.granted_offset = out_data_r.granted_offset;
  assign out_ch.block_bytes    = out_data_r.block_bytes;
endmodule

// ===== design/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== design/bba_ctrl.sv =====
// Allocation search and free merge sequencer over the control table
`include "buddy_block_allocator_unit_macros.svh"

module bba_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  bba_in_if.sink                        in_ch,
  output logic                          res_valid,
  output bba_pkg::res_t                 res,
  input  logic                          res_ready,
  output bba_pkg::mem_req_t             mem_req,
  input  logic [bba_pkg::SIZE_W-1:0]    mem_rdata
);
  bba_pkg::state_t state_r, state_nxt;
  logic [bba_pkg::SLOT_W-1:0] slot_r, slot_nxt, clr_r, clr_nxt;
  logic [bba_pkg::SIZE_W-1:0] sz_r, sz_nxt, need_r, need_nxt;
  logic [bba_pkg::OFF_W-1:0]  off_r, off_nxt;
  bba_pkg::res_t              res_r, res_nxt;

  logic                       accept;
  logic [bba_pkg::SIZE_W-1:0] esz, half;
  logic [bba_pkg::SLOT_W-1:0] units, half_units;
  logic a_hit, a_take, a_split, a_desc, at_root, is_left, f_bad, f_stop;

  assign accept     = in_ch.valid && in_ch.ready;
  assign esz        = {mem_rdata[bba_pkg::SIZE_W-1:1], 1'b0};
  assign half       = sz_r >> 1;
  assign units      = sz_r[bba_pkg::OFF_W-1:bba_pkg::MIN_SHIFT];
  assign half_units = half[bba_pkg::OFF_W-1:bba_pkg::MIN_SHIFT];
  assign a_hit      = (esz == sz_r);
  assign a_take     = a_hit && !mem_rdata[0] && (sz_r == need_r);
  assign a_split    = a_hit && !mem_rdata[0] && (sz_r != need_r);
  assign a_desc     = !a_hit && (esz != '0) && (esz <= sz_r) && (half >= need_r);
  assign at_root    = (sz_r >= bba_pkg::MAX_BLOCK);
  assign is_left    = ((slot_r & units) == '0);
  assign f_bad      = (mem_rdata == '0) || !mem_rdata[0];
  assign f_stop     = (sz_r >= bba_pkg::MAX_BLOCK) || (units == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_CLR:    if (clr_r == '1) state_nxt = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.mode == bba_pkg::MODE_ALLOC) begin
            state_nxt = (in_ch.request_size > bba_pkg::MAX_BLOCK) ?
                        bba_pkg::S_DONE : bba_pkg::S_ARD;
          end else begin
            state_nxt = (in_ch.block_offset[bba_pkg::MIN_SHIFT-1:0] != '0) ?
                        bba_pkg::S_DONE : bba_pkg::S_FRD;
          end
        end
      end
      bba_pkg::S_ARD:    state_nxt = bba_pkg::S_AEV;
      bba_pkg::S_AEV: begin
        if (a_take)       state_nxt = bba_pkg::S_DONE;
        else if (a_split) state_nxt = bba_pkg::S_ASPLIT;
        else if (a_desc)  state_nxt = bba_pkg::S_ARD;
        else              state_nxt = bba_pkg::S_ABT;
      end
      bba_pkg::S_ASPLIT: state_nxt = bba_pkg::S_ARD;
      bba_pkg::S_ABT: begin
        if (at_root)      state_nxt = bba_pkg::S_DONE;
        else if (is_left) state_nxt = bba_pkg::S_ARD;
      end
      bba_pkg::S_FRD:    state_nxt = bba_pkg::S_FEV;
      bba_pkg::S_FEV:    state_nxt = f_bad ? bba_pkg::S_DONE : bba_pkg::S_FCHK;
      bba_pkg::S_FCHK:   state_nxt = f_stop ? bba_pkg::S_DONE : bba_pkg::S_FBEV;
      bba_pkg::S_FBEV:   state_nxt = (mem_rdata != sz_r) ? bba_pkg::S_DONE : bba_pkg::S_FWLO;
      bba_pkg::S_FWLO:   state_nxt = bba_pkg::S_FCHK;
      bba_pkg::S_DONE:   if (res_ready) state_nxt = bba_pkg::S_IDLE;
      default:           state_nxt = bba_pkg::S_CLR;
    endcase
  end

  always_comb begin
    slot_nxt = slot_r;
    sz_nxt   = sz_r;
    need_nxt = need_r;
    off_nxt  = off_r;
    res_nxt  = res_r;
    clr_nxt  = clr_r;
    mem_req  = '0;
    case (state_r)
      bba_pkg::S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = (clr_r == '0) ? bba_pkg::MAX_BLOCK : '0;
        clr_nxt       = clr_r + 1'b1;
      end
      bba_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt  = '{status: bba_pkg::STAT_NOSPACE, granted_offset: '0, block_bytes: '0};
          slot_nxt = '0;
          sz_nxt   = bba_pkg::MAX_BLOCK;
          need_nxt = bba_pkg::calc_need(in_ch.request_size);
          off_nxt  = in_ch.block_offset;
          if (in_ch.mode == bba_pkg::MODE_FREE) begin
            res_nxt.status = bba_pkg::STAT_BADADDR;
            slot_nxt = in_ch.block_offset[bba_pkg::OFF_W-1:bba_pkg::MIN_SHIFT];
          end
        end
      end
      bba_pkg::S_ARD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = slot_r;
      end
      bba_pkg::S_AEV: begin
        if (a_take) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_r;
          mem_req.wdata = sz_r | bba_pkg::SIZE_W'(1);
          res_nxt = '{status: bba_pkg::STAT_OK,
                      granted_offset: {slot_r, bba_pkg::MIN_SHIFT'(0)},
                      block_bytes: need_r};
        end else if (a_split) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_r;
          mem_req.wdata = half;
        end else if (a_desc) begin
          sz_nxt = half;
        end
      end
      bba_pkg::S_ASPLIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_r | half_units;
        mem_req.wdata = half;
        sz_nxt        = half;
      end
      bba_pkg::S_ABT: begin
        if (!at_root) begin
          if (is_left) begin
            slot_nxt = slot_r | units;
          end else begin
            slot_nxt = slot_r & ~units;
            sz_nxt   = sz_r << 1;
          end
        end
      end
      bba_pkg::S_FRD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = slot_r;
      end
      bba_pkg::S_FEV: begin
        if (!f_bad) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_r;
          mem_req.wdata = esz;
          sz_nxt        = esz;
        end
      end
      bba_pkg::S_FCHK: begin
        if (f_stop) begin
          res_nxt = '{status: bba_pkg::STAT_OK, granted_offset: off_r, block_bytes: sz_r};
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot_r ^ units;
        end
      end
      bba_pkg::S_FBEV: begin
        if (mem_rdata != sz_r) begin
          res_nxt = '{status: bba_pkg::STAT_OK, granted_offset: off_r, block_bytes: sz_r};
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_r | units;
          mem_req.wdata = '0;
          slot_nxt      = slot_r & ~units;
          sz_nxt        = sz_r << 1;
        end
      end
      bba_pkg::S_FWLO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_r;
        mem_req.wdata = sz_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == bba_pkg::S_IDLE);
  assign res_valid   = (state_r == bba_pkg::S_DONE);
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    sz_r   <= sz_nxt;
    need_r <= need_nxt;
    off_r  <= off_nxt;
    res_r  <= res_nxt;
  end

  `BBA_ASSERT_NOW(a_no_rw_clash, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "table read and write hit the same entry")
  `BBA_ASSERT_NOW(a_size_nonzero, state_r == bba_pkg::S_ARD || state_r == bba_pkg::S_AEV || state_r == bba_pkg::S_ABT, sz_r != '0, "search node size is zero")
  `BBA_ASSERT_NEXT(a_leave_idle, accept, state_r != bba_pkg::S_IDLE, "accepted beat left the sequencer idle")
endmodule

// ===== test/buddy_block_allocator_unit_checker.sv =====
// Checker: watches both channels, predicts allocator results and compares them
`timescale 1ns / 1ps
module buddy_block_allocator_unit_checker (
  input  logic     clk,
  input  logic     rst_n,
  bba_in_if.sink   in_mon,
  bba_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending_count
);
  import bba_pkg::*;

  logic [SIZE_W-1:0] table_shadow [SLOT_COUNT];
  res_t expected_results [$];

  function automatic logic [SIZE_W-1:0] slot_rd(int unsigned s);
    if (s >= SLOT_COUNT) return '0;
    return table_shadow[s];
  endfunction

  function automatic void slot_wr(int unsigned s, int unsigned v);
    if (s < SLOT_COUNT) table_shadow[s] = SIZE_W'(v);
  endfunction

  function automatic bit find_block(int unsigned s, int unsigned sz, int unsigned need,
                                    ref int unsigned got);
    int unsigned e, esz, half, mid;
    if (s >= SLOT_COUNT || sz < need || sz < MIN_BLOCK) return 0;
    e    = slot_rd(s);
    esz  = e & ~32'd1;
    half = sz >> 1;
    mid  = s + half / MIN_BLOCK;
    if (esz == sz) begin
      if (e & 1) return 0;
      if (sz == need) begin
        slot_wr(s, sz | 1);
        got = s;
        return 1;
      end
      if (half < need || mid >= SLOT_COUNT) return 0;
      slot_wr(s, half);
      slot_wr(mid, half);
      return find_block(s, half, need, got);
    end
    if (esz == 0 || esz > sz || half < need) return 0;
    if (find_block(s, half, need, got)) return 1;
    return find_block(mid, half, need, got);
  endfunction

  function automatic res_t predict_beat(logic mode, int unsigned req, int unsigned off);
    res_t r;
    int unsigned need, got, s, e, cur, sz, units, bud, lo, hi;
    r = '0;
    got = 0;
    if (mode == MODE_ALLOC) begin
      need = MIN_BLOCK;
      if (req > MAX_BLOCK) r.status = STAT_NOSPACE;
      else begin
        while (need < req) need <<= 1;
        if (find_block(0, MAX_BLOCK, need, got)) begin
          r.granted_offset = OFF_W'(got * MIN_BLOCK);
          r.block_bytes    = SIZE_W'(need);
        end else r.status = STAT_NOSPACE;
      end
    end else begin
      s = off / MIN_BLOCK;
      e = slot_rd(s);
      if (off % MIN_BLOCK != 0 || s >= SLOT_COUNT || e == 0 || (e & 1) == 0) begin
        r.status = STAT_BADADDR;
      end else begin
        cur = s;
        sz  = e & ~32'd1;
        slot_wr(cur, sz);
        while (sz < MAX_BLOCK) begin
          units = sz / MIN_BLOCK;
          bud   = cur ^ units;
          if (units == 0 || bud >= SLOT_COUNT) break;
          if (slot_rd(bud) != sz) break;
          lo = cur < bud ? cur : bud;
          hi = cur < bud ? bud : cur;
          slot_wr(hi, 0);
          sz <<= 1;
          slot_wr(lo, sz);
          cur = lo;
        end
        r.granted_offset = OFF_W'(off);
        r.block_bytes    = SIZE_W'(sz);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    foreach (table_shadow[i]) table_shadow[i] = '0;
    table_shadow[0] = MAX_BLOCK;
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_beat(in_mon.mode, in_mon.request_size,
                                                in_mon.block_offset));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_mon.status, exp_r.status));
          if (out_mon.granted_offset !== exp_r.granted_offset)
            report_mismatch($sformatf("granted_offset %0d, expected %0d",
                                      out_mon.granted_offset, exp_r.granted_offset));
          if (out_mon.block_bytes !== exp_r.block_bytes)
            report_mismatch($sformatf("block_bytes %0d, expected %0d",
                                      out_mon.block_bytes, exp_r.block_bytes));
        end
      end
    end
    // expected result queue depth for the stimulus side
    pending_count = expected_results.size();
  end
endmodule

// ===== test/testbench.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module testbench;
  import bba_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  bit   calm;
  bit   stim_done;
  int unsigned live_blocks [$];

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  buddy_block_allocator_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  buddy_block_allocator_unit_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 0;
  always #2 clk = ~clk;

  // track live blocks from the result side so frees mostly hit real blocks
  logic          last_mode [$];
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) last_mode.push_back(in_ch.mode);
    if (rst_n && out_ch.valid && out_ch.ready && last_mode.size() > 0) begin
      if (last_mode.pop_front() == MODE_ALLOC && out_ch.status == STAT_OK)
        live_blocks.push_back(out_ch.granted_offset);
    end
  end

  task automatic send_beat(logic mode, int unsigned req, int unsigned off);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.request_size <= SIZE_W'(req);
    in_ch.block_offset <= OFF_W'(off);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic free_random_live();
    int idx;
    if (live_blocks.size() == 0) begin
      send_beat(MODE_FREE, 0, $urandom_range(0, 511) * 32);
    end else begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      send_beat(MODE_FREE, $urandom, live_blocks[idx]);
      live_blocks.delete(idx);
    end
  endtask

  function automatic int unsigned rand_request();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 32767);
      1:       return $urandom_range(4096, 16384);
      2, 3:    return $urandom_range(0, 1024);
      default: return $urandom_range(0, 256);
    endcase
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    int stall;
    if (!rst_n) out_ch.ready <= 1'b1;
    else if (!calm && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 8);
      out_ch.ready <= 1'b0;
      repeat (stall) @(negedge clk);
      out_ch.ready <= 1'b1;
    end else out_ch.ready <= 1'b1;
  end

  initial begin
    in_ch.valid = 0; in_ch.mode = 0; in_ch.request_size = 0; in_ch.block_offset = 0;
    out_ch.ready = 1;
    rst_n = 0;
    calm = 0;
    stim_done = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed
    send_beat(MODE_ALLOC, 0, 0);
    send_beat(MODE_ALLOC, 32767, 0);
    send_beat(MODE_ALLOC, 16385, 16383);
    send_beat(MODE_ALLOC, 33, 0);
    send_beat(MODE_ALLOC, 1, 0);
    send_beat(MODE_FREE, 0, 0);
    send_beat(MODE_FREE, 0, 0);
    send_beat(MODE_FREE, 0, 65);
    send_beat(MODE_FREE, 0, 16383);
    send_beat(MODE_FREE, 0, 16352);
    send_beat(MODE_FREE, 0, 64);
    send_beat(MODE_FREE, 0, 64);
    send_beat(MODE_ALLOC, 16384, 0);
    send_beat(MODE_ALLOC, 32, 0);
    send_beat(MODE_FREE, 0, 0);
    send_beat(MODE_FREE, 0, 0);
    send_beat(MODE_ALLOC, 8000, 0);
    send_beat(MODE_ALLOC, 8192, 0);
    send_beat(MODE_ALLOC, 32, 0);
    send_beat(MODE_FREE, 0, 0);
    send_beat(MODE_FREE, 0, 8192);
    send_beat(MODE_FREE, 0, 16383);
    live_blocks.delete();
    // random
    for (int i = 0; i < 650; i++) begin
      if (i == 560) calm = 1;
      case ($urandom_range(0, 9))
        0:             send_beat(MODE_FREE, $urandom, $urandom_range(0, 16383));
        1, 2, 3, 4:    free_random_live();
        default:       send_beat(MODE_ALLOC, rand_request(), $urandom);
      endcase
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
    wait (pending_count == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("buddy_block_allocator_unit: match");
    else $display("buddy_block_allocator_unit: mismatch");
    $finish;
  end

  initial begin
    #40000000;
    $display("buddy_block_allocator_unit: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/bba_pkg.sv
design/bba_if.sv
design/bba_ram.sv
design/bba_ctrl.sv
design/buddy_block_allocator_unit.sv
test/buddy_block_allocator_unit_checker.sv
test/testbench.sv
